// File: hdl/tpd_pkg.sv
// shared types and constants of the transport packet deframer
// used by tpd_ctrl, tpd_dpath and transport_packet_deframer_top
package tpd_pkg;

  typedef enum logic [14:0] {
    PH_IDLE     = 15'b000000000000001,
    PH_TYPE     = 15'b000000000000010,
    PH_VERSION  = 15'b000000000000100,
    PH_SUBVER   = 15'b000000000001000,
    PH_OPTIONS  = 15'b000000000010000,
    PH_SEQ      = 15'b000000000100000,
    PH_TS       = 15'b000000001000000,
    PH_COUNT    = 15'b000000010000000,
    PH_CHECK    = 15'b000000100000000,
    PH_SIZES    = 15'b000001000000000,
    PH_FINISH   = 15'b000010000000000,
    PH_SEEK_RD  = 15'b000100000000000,
    PH_SEEK_CHK = 15'b001000000000000,
    PH_BODY     = 15'b010000000000000,
    PH_DROP     = 15'b100000000000000
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_TYPE    = 2'd1,
    ST_VERSION = 2'd2,
    ST_MAP     = 2'd3
  } status_e;

  typedef enum logic {
    KIND_HEADER = 1'b0,
    KIND_BODY   = 1'b1
  } kind_e;

  typedef enum logic {
    ACT_START = 1'b0,
    ACT_BYTE  = 1'b1
  } action_e;

  typedef enum logic [2:0] {
    CFG_TYPE      = 3'd0,
    CFG_VERSION   = 3'd1,
    CFG_TS_MASK   = 3'd2,
    CFG_WIDE_MASK = 3'd3,
    CFG_MAX_SUB   = 3'd4
  } cfg_idx_e;

  // last byte position within each multi-byte field
  localparam logic [3:0] SeqLast    = 4'd7;
  localparam logic [3:0] TsLast     = 4'd7;
  localparam logic [3:0] CountLast  = 4'd3;
  localparam logic [3:0] NarrowLast = 4'd1;
  localparam logic [3:0] WideLast   = 4'd3;

  typedef struct packed {
    logic    start;
    logic    hdr_byte;
    logic    type_ld;
    logic    opts_ld;
    logic    seq_sh;
    logic    ts_sh;
    logic    cnt_sh;
    logic    check;
    logic    size_sh;
    logic    size_commit;
    logic    seek_clr;
    logic    seek_from_cur;
    logic    seek_next;
    logic    seek_rd;
    logic    seek_found;
    logic    body_byte;
    logic    pend_ld;
    logic    emit_hdr;
    status_e hdr_status;
    logic    emit_body;
    logic    emit_pend;
    logic    eop;
  } cmd_t;

  typedef struct packed {
    logic type_ok;
    logic ver_ok;
    logic ts_en;
    logic wide;
    logic check_bad;
    logic count_zero;
    logic fill_last;
    logic sum_bad;
    logic seek_end;
    logic rd_nonzero;
    logic left_one;
    logic pend;
    logic out_free;
  } sts_t;

endpackage

// File: hdl/transport_packet_deframer_top.sv
// Transport packet deframer. Input items on s_axis: tuser 0 starts a packet
// with its byte length, tuser 1 carries one packet byte, big-endian fields.
// Output items on m_axis: tuser 0 is the header result (status, type,
// sequence, timestamp, count), tuser 1 a body byte with its virtual packet
// index, end-of-subpacket in tdata and end-of-packet on tlast.
// Configuration registers are written on cfg_* (index, data); ready is
// always high and writes take effect on the next cycle.
// Each result is registered in the output register. The count check and
// the size sum check each hold input off. Finding a non-empty size entry
// reads the size table once per entry visited, with input held off; a body
// item that ends a subpacket is held until the next non-empty entry is
// found or the table ends, and is then sent with end-of-subpacket set.
// A single output register decouples the sides; while a result waits and
// m_axis_tready is low, s_axis_tready drops. Reset clears the parse state
// to idle and loads the register defaults; bytes before a start are dropped.
// Depends on tpd_pkg, tpd_ctrl and tpd_dpath.
module transport_packet_deframer_top #(
  parameter int MAX_SUBPACKETS = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [39:0]  s_axis_tdata,  // packet_length[30:0], data_byte[38:31], pad
  input  logic         s_axis_tuser,  // action
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[1:0], packet_type[9:2], sequence_number[73:10], time_stamp[121:74],
  // subpacket_count[128:122], subpacket_index[134:129], body_byte[142:135],
  // end_of_subpacket[143]
  output logic [143:0] m_axis_tdata,
  output logic         m_axis_tuser,  // result_kind
  output logic         m_axis_tlast,  // end_of_packet
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [7:0]   cfg_data_i
);

  tpd_pkg::cmd_t cmd;
  tpd_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  tpd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_action_i (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tpd_dpath #(
    .MaxSub (MAX_SUBPACKETS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_length_i (s_axis_tdata[30:0]),
    .in_byte_i   (s_axis_tdata[38:31]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_kind_o  (m_axis_tuser),
    .out_data_o  (m_axis_tdata),
    .out_eop_o   (m_axis_tlast)
  );

endmodule

// File: hdl/tpd_ctrl.sv
// parse state machine of the transport packet deframer
// depends on tpd_pkg; drives tpd_dpath through cmd_t, reads sts_t
module tpd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_action_i,
  output logic          in_ready_o,
  input  tpd_pkg::sts_t sts_i,
  output tpd_pkg::cmd_t cmd_o
);

  tpd_pkg::phase_e phase_q, phase_d;
  logic [3:0]      fcnt_q, fcnt_d;
  logic            accepting;
  logic            fire;

  always_comb begin
    unique case (phase_q)
      tpd_pkg::PH_CHECK, tpd_pkg::PH_FINISH,
      tpd_pkg::PH_SEEK_RD, tpd_pkg::PH_SEEK_CHK: accepting = 1'b0;
      default: accepting = 1'b1;
    endcase
  end

  assign in_ready_o = accepting & sts_i.out_free;
  assign fire       = in_valid_i & in_ready_o;

  always_comb begin
    cmd_o   = '0;
    phase_d = phase_q;
    fcnt_d  = fcnt_q;
    if (fire && in_action_i == tpd_pkg::ACT_START) begin
      cmd_o.start = 1'b1;
      phase_d     = tpd_pkg::PH_TYPE;
      fcnt_d      = '0;
    end else if (fire) begin
      unique case (phase_q)
        tpd_pkg::PH_TYPE: begin
          cmd_o.hdr_byte = 1'b1;
          cmd_o.type_ld  = 1'b1;
          if (!sts_i.type_ok) begin
            cmd_o.emit_hdr   = 1'b1;
            cmd_o.hdr_status = tpd_pkg::ST_TYPE;
            phase_d          = tpd_pkg::PH_DROP;
          end else begin
            phase_d = tpd_pkg::PH_VERSION;
          end
        end
        tpd_pkg::PH_VERSION: begin
          cmd_o.hdr_byte = 1'b1;
          if (!sts_i.ver_ok) begin
            cmd_o.emit_hdr   = 1'b1;
            cmd_o.hdr_status = tpd_pkg::ST_VERSION;
            phase_d          = tpd_pkg::PH_DROP;
          end else begin
            phase_d = tpd_pkg::PH_SUBVER;
          end
        end
        tpd_pkg::PH_SUBVER: begin
          cmd_o.hdr_byte = 1'b1;
          phase_d        = tpd_pkg::PH_OPTIONS;
        end
        tpd_pkg::PH_OPTIONS: begin
          cmd_o.hdr_byte = 1'b1;
          cmd_o.opts_ld  = 1'b1;
          fcnt_d         = '0;
          phase_d        = tpd_pkg::PH_SEQ;
        end
        tpd_pkg::PH_SEQ: begin
          cmd_o.hdr_byte = 1'b1;
          cmd_o.seq_sh   = 1'b1;
          if (fcnt_q == tpd_pkg::SeqLast) begin
            fcnt_d  = '0;
            phase_d = sts_i.ts_en ? tpd_pkg::PH_TS : tpd_pkg::PH_COUNT;
          end else begin
            fcnt_d = fcnt_q + 4'd1;
          end
        end
        tpd_pkg::PH_TS: begin
          cmd_o.hdr_byte = 1'b1;
          cmd_o.ts_sh    = 1'b1;
          if (fcnt_q == tpd_pkg::TsLast) begin
            fcnt_d  = '0;
            phase_d = tpd_pkg::PH_COUNT;
          end else begin
            fcnt_d = fcnt_q + 4'd1;
          end
        end
        tpd_pkg::PH_COUNT: begin
          cmd_o.hdr_byte = 1'b1;
          cmd_o.cnt_sh   = 1'b1;
          if (fcnt_q == tpd_pkg::CountLast) begin
            fcnt_d  = '0;
            phase_d = tpd_pkg::PH_CHECK;
          end else begin
            fcnt_d = fcnt_q + 4'd1;
          end
        end
        tpd_pkg::PH_SIZES: begin
          cmd_o.size_sh = 1'b1;
          if (fcnt_q == (sts_i.wide ? tpd_pkg::WideLast : tpd_pkg::NarrowLast)) begin
            fcnt_d            = '0;
            cmd_o.size_commit = 1'b1;
            if (sts_i.fill_last) phase_d = tpd_pkg::PH_FINISH;
          end else begin
            fcnt_d = fcnt_q + 4'd1;
          end
        end
        tpd_pkg::PH_BODY: begin
          cmd_o.body_byte = 1'b1;
          if (sts_i.left_one) begin
            // last byte of this entry: hold it until the next non-empty entry is found or the table ends
            cmd_o.pend_ld       = 1'b1;
            cmd_o.seek_from_cur = 1'b1;
            phase_d             = tpd_pkg::PH_SEEK_RD;
          end else begin
            cmd_o.emit_body = 1'b1;
          end
        end
        default: ;
      endcase
    end else begin
      unique case (phase_q)
        tpd_pkg::PH_CHECK: begin
          if (sts_i.check_bad) begin
            if (sts_i.out_free) begin
              cmd_o.emit_hdr   = 1'b1;
              cmd_o.hdr_status = tpd_pkg::ST_MAP;
              phase_d          = tpd_pkg::PH_DROP;
            end
          end else begin
            cmd_o.check = 1'b1;
            phase_d     = sts_i.count_zero ? tpd_pkg::PH_FINISH : tpd_pkg::PH_SIZES;
          end
        end
        tpd_pkg::PH_FINISH: begin
          if (sts_i.out_free) begin
            cmd_o.emit_hdr = 1'b1;
            if (sts_i.sum_bad) begin
              cmd_o.hdr_status = tpd_pkg::ST_MAP;
              phase_d          = tpd_pkg::PH_DROP;
            end else begin
              cmd_o.hdr_status = tpd_pkg::ST_OK;
              cmd_o.seek_clr   = 1'b1;
              phase_d          = tpd_pkg::PH_SEEK_RD;
            end
          end
        end
        tpd_pkg::PH_SEEK_RD: begin
          if (!sts_i.seek_end) begin
            cmd_o.seek_rd = 1'b1;
            phase_d       = tpd_pkg::PH_SEEK_CHK;
          end else if (!sts_i.pend) begin
            phase_d = tpd_pkg::PH_DROP;
          end else if (sts_i.out_free) begin
            cmd_o.emit_pend = 1'b1;
            cmd_o.eop       = 1'b1;
            phase_d         = tpd_pkg::PH_DROP;
          end
        end
        tpd_pkg::PH_SEEK_CHK: begin
          if (!sts_i.rd_nonzero) begin
            cmd_o.seek_next = 1'b1;
            phase_d         = tpd_pkg::PH_SEEK_RD;
          end else if (!sts_i.pend) begin
            cmd_o.seek_found = 1'b1;
            phase_d          = tpd_pkg::PH_BODY;
          end else if (sts_i.out_free) begin
            cmd_o.emit_pend  = 1'b1;
            cmd_o.seek_found = 1'b1;
            phase_d          = tpd_pkg::PH_BODY;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= tpd_pkg::PH_IDLE;
      fcnt_q  <= '0;
    end else begin
      phase_q <= phase_d;
      fcnt_q  <= fcnt_d;
    end
  end

endmodule

// File: hdl/tpd_dpath.sv
// datapath of the transport packet deframer: config registers, header
// fields, size table memory, entry seek and output register; uses tpd_pkg
module tpd_dpath #(
  parameter int MaxSub = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_valid_i,
  input  logic [2:0]    cfg_index_i,
  input  logic [7:0]    cfg_data_i,
  input  logic [30:0]   in_length_i,
  input  logic [7:0]    in_byte_i,
  input  tpd_pkg::cmd_t cmd_i,
  output tpd_pkg::sts_t sts_o,
  input  logic          out_ready_i,
  output logic          out_valid_o,
  output logic          out_kind_o,
  output logic [143:0]  out_data_o,
  output logic          out_eop_o
);

  localparam int CntW = $clog2(MaxSub + 1);
  localparam int IdxW = (MaxSub > 1) ? $clog2(MaxSub) : 1;
  localparam int SumW = 32 + CntW;

  logic [7:0]  exp_type_q, exp_ver_q, ts_mask_q, wide_mask_q;
  logic [6:0]  max_sub_q;

  logic [7:0]       type_q, opts_q;
  logic [63:0]      seq_q;
  logic [47:0]      ts_q;
  logic [31:0]      cnt_q;
  logic [32:0]      rem_q;
  logic             wide_q;
  logic [SumW-1:0]  sum_q;
  logic [CntW-1:0]  fill_q, seek_q;
  logic [31:0]      entry_q, left_q, rd_q;
  logic [IdxW-1:0]  cur_q;
  logic             pend_q;
  logic [7:0]       pend_byte_q;
  logic [5:0]       pend_idx_q;

  logic [31:0] size_mem [MaxSub];

  logic             out_valid_q, out_kind_q, out_eop_q;
  logic [143:0]     out_data_q;

  logic [31:0] limit;
  logic        wide_now;
  logic [32:0] cw;
  logic [32:0] rem_sub;
  logic [31:0] new_entry;
  logic [6:0]  cnt_sat;
  logic [7:0]  hdr_type;
  logic        out_free;

  assign out_free  = !out_valid_q || out_ready_i;
  assign wide_now  = |(opts_q & wide_mask_q);
  assign limit     = ({25'd0, max_sub_q} < 32'(MaxSub)) ? {25'd0, max_sub_q} : 32'(MaxSub);
  assign cw        = wide_now ? (33'(cnt_q[CntW-1:0]) << 2) : (33'(cnt_q[CntW-1:0]) << 1);
  assign rem_sub   = rem_q - cw;
  assign new_entry = {entry_q[23:0], in_byte_i};
  assign cnt_sat   = (|cnt_q[31:7]) ? 7'd127 : cnt_q[6:0];
  assign hdr_type  = cmd_i.type_ld ? in_byte_i : type_q;

  always_comb begin
    sts_o            = '0;
    sts_o.type_ok    = in_byte_i == exp_type_q;
    sts_o.ver_ok     = in_byte_i == exp_ver_q;
    sts_o.ts_en      = |(opts_q & ts_mask_q);
    sts_o.wide       = wide_q;
    sts_o.check_bad  = rem_q[32] | (cnt_q > limit) | rem_sub[32];
    sts_o.count_zero = cnt_q == 32'd0;
    sts_o.fill_last  = (32'(fill_q) + 32'd1) >= cnt_q;
    sts_o.sum_bad    = sum_q != SumW'(rem_q[31:0]);
    sts_o.seek_end   = seek_q >= fill_q;
    sts_o.rd_nonzero = rd_q != 32'd0;
    sts_o.left_one   = left_q == 32'd1;
    sts_o.pend       = pend_q;
    sts_o.out_free   = out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_type_q  <= 8'd0;
      exp_ver_q   <= 8'd4;
      ts_mask_q   <= 8'd0;
      wide_mask_q <= 8'd0;
      max_sub_q   <= 7'd64;
      type_q      <= '0;
      opts_q      <= '0;
      seq_q       <= '0;
      ts_q        <= '0;
      cnt_q       <= '0;
      rem_q       <= '0;
      wide_q      <= 1'b0;
      sum_q       <= '0;
      fill_q      <= '0;
      seek_q      <= '0;
      entry_q     <= '0;
      left_q      <= '0;
      cur_q       <= '0;
      pend_q      <= 1'b0;
      pend_byte_q <= '0;
      pend_idx_q  <= '0;
      out_valid_q <= 1'b0;
      out_kind_q  <= tpd_pkg::KIND_HEADER;
      out_eop_q   <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          tpd_pkg::CFG_TYPE:      exp_type_q  <= cfg_data_i;
          tpd_pkg::CFG_VERSION:   exp_ver_q   <= cfg_data_i;
          tpd_pkg::CFG_TS_MASK:   ts_mask_q   <= cfg_data_i;
          tpd_pkg::CFG_WIDE_MASK: wide_mask_q <= cfg_data_i;
          tpd_pkg::CFG_MAX_SUB:   max_sub_q   <= cfg_data_i[6:0];
          default: ;
        endcase
      end

      if (cmd_i.start) begin
        type_q  <= '0;
        opts_q  <= '0;
        seq_q   <= '0;
        ts_q    <= '0;
        cnt_q   <= '0;
        rem_q   <= {2'b00, in_length_i};
        wide_q  <= 1'b0;
        sum_q   <= '0;
        fill_q  <= '0;
        seek_q  <= '0;
        entry_q <= '0;
        left_q  <= '0;
        cur_q   <= '0;
        pend_q  <= 1'b0;
      end
      if (cmd_i.hdr_byte) rem_q  <= rem_q - 33'd1;
      if (cmd_i.type_ld)  type_q <= in_byte_i;
      if (cmd_i.opts_ld)  opts_q <= in_byte_i;
      if (cmd_i.seq_sh)   seq_q  <= {seq_q[55:0], in_byte_i};
      if (cmd_i.ts_sh)    ts_q   <= {ts_q[39:0], in_byte_i};
      if (cmd_i.cnt_sh)   cnt_q  <= {cnt_q[23:0], in_byte_i};

      if (cmd_i.check) begin
        wide_q  <= wide_now;
        rem_q   <= rem_sub;
        fill_q  <= '0;
        sum_q   <= '0;
        entry_q <= '0;
      end

      if (cmd_i.size_commit) begin
        entry_q <= '0;
        sum_q   <= sum_q + SumW'(new_entry);
        fill_q  <= fill_q + CntW'(1);
      end else if (cmd_i.size_sh) begin
        entry_q <= new_entry;
      end

      if (cmd_i.seek_clr)      seek_q <= '0;
      if (cmd_i.seek_from_cur) seek_q <= CntW'(cur_q) + CntW'(1);
      if (cmd_i.seek_next)     seek_q <= seek_q + CntW'(1);
      if (cmd_i.seek_found) begin
        cur_q  <= seek_q[IdxW-1:0];
        left_q <= rd_q;
      end
      if (cmd_i.body_byte) left_q <= left_q - 32'd1;

      if (cmd_i.pend_ld) begin
        pend_q      <= 1'b1;
        pend_byte_q <= in_byte_i;
        pend_idx_q  <= 6'(cur_q);
      end
      if (cmd_i.emit_pend) pend_q <= 1'b0;

      if (cmd_i.emit_hdr) begin
        out_valid_q <= 1'b1;
        out_kind_q  <= tpd_pkg::KIND_HEADER;
        out_eop_q   <= 1'b0;
        out_data_q  <= {9'd0, 6'd0, cnt_sat, ts_q, seq_q, hdr_type, cmd_i.hdr_status};
      end else if (cmd_i.emit_body) begin
        out_valid_q <= 1'b1;
        out_kind_q  <= tpd_pkg::KIND_BODY;
        out_eop_q   <= 1'b0;
        out_data_q  <= {1'b0, in_byte_i, 6'(cur_q), 7'd0, 48'd0, 64'd0, 8'd0, 2'd0};
      end else if (cmd_i.emit_pend) begin
        out_valid_q <= 1'b1;
        out_kind_q  <= tpd_pkg::KIND_BODY;
        out_eop_q   <= cmd_i.eop;
        out_data_q  <= {1'b1, pend_byte_q, pend_idx_q, 7'd0, 48'd0, 64'd0, 8'd0, 2'd0};
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // size table, written in fill order, read one entry at a time by the seek
  always_ff @(posedge clk_i) begin
    if (cmd_i.size_commit) size_mem[fill_q[IdxW-1:0]] <= new_entry;
    if (cmd_i.seek_rd)     rd_q <= size_mem[seek_q[IdxW-1:0]];
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_data_o  = out_data_q;
  assign out_eop_o   = out_eop_q;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill_q) <= 32'(MaxSub)) else $error("size table fill beyond depth");
  a_commit_in_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.size_commit |-> 32'(fill_q) < cnt_q) else $error("size entry beyond count");
  a_pend_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_pend |-> pend_q) else $error("held body item emitted without one held");
  a_found_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.seek_found |=> left_q != 32'd0) else $error("seek landed on an empty entry");
`endif

endmodule

// File: verif/transport_packet_deframer_top_tb.sv
// testbench for transport_packet_deframer_top: drives whole and broken packets,
// predicts header and body items in a behavioral model and checks every item
// depends on tpd_pkg and the deframer rtl
module transport_packet_deframer_top_tb;

  localparam int MaxSub   = 64;
  localparam int Drain    = 400;
  localparam int Watchdog = 20000;

  typedef enum int {
    DP_IDLE, DP_TYPE, DP_VERSION, DP_SUBVER, DP_OPTIONS, DP_SEQ, DP_TS,
    DP_COUNT, DP_SIZES, DP_BODY, DP_DROP
  } deframe_phase_e;

  typedef enum int {
    PK_GOOD, PK_BAD_TYPE, PK_BAD_VERSION, PK_BAD_LENGTH, PK_OVER_COUNT,
    PK_CUT, PK_TRAILING
  } pkt_flavor_e;

  typedef struct {
    logic        kind;
    logic [1:0]  status;
    logic [7:0]  ptype;
    logic [63:0] seq;
    logic [47:0] ts;
    logic [6:0]  count;
    logic [5:0]  vp_idx;
    logic [7:0]  body;
    logic        eos;
    logic        eop;
  } deframe_item_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [39:0]  s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [143:0] m_axis_tdata;
  logic         m_axis_tuser;
  logic         m_axis_tlast;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [2:0]   cfg_index_i = '0;
  logic [7:0]   cfg_data_i = '0;

  always #1 clk_i = ~clk_i;

  transport_packet_deframer_top #(.MAX_SUBPACKETS(MaxSub)) u_dut (.*);

  // model copy of the registers
  logic [7:0] exp_type_r, exp_ver_r, ts_mask_r, wide_mask_r;
  logic [6:0] max_sub_r;

  // model copy of the parse state
  deframe_phase_e dphase;
  int unsigned    fld_cnt;
  longint         remaining;
  logic [7:0]     opts, hdr_type;
  logic [63:0]    seq_sh, ts_sh, sum_acc;
  logic [31:0]    cnt_sh, vp_left;
  logic [31:0]    size_mem [MaxSub];
  int unsigned    fill_idx, cur_vp, ent_w;

  deframe_item_t  pending_q[$];
  int             errors = 0;
  int             src_idle = 0, snk_stall = 0;
  logic [7:0]     pkt_q[$];

  function automatic bit find_nonempty(int unsigned from);
    for (int unsigned i = from; i < fill_idx && i < MaxSub; i++) begin
      if (size_mem[i] != 0) begin
        cur_vp  = i;
        vp_left = size_mem[i];
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  task automatic push_header(logic [1:0] st);
    deframe_item_t e;
    e = '{default: '0};
    e.kind   = tpd_pkg::KIND_HEADER;
    e.status = st;
    e.ptype  = hdr_type;
    e.seq    = seq_sh;
    e.ts     = ts_sh[47:0];
    e.count  = (cnt_sh > 127) ? 7'd127 : cnt_sh[6:0];
    pending_q.push_back(e);
    if (st != tpd_pkg::ST_OK) dphase = DP_DROP;
  endtask

  task automatic close_map();
    if (sum_acc != 64'(remaining)) begin
      push_header(tpd_pkg::ST_MAP);
    end else begin
      push_header(tpd_pkg::ST_OK);
      dphase = find_nonempty(0) ? DP_BODY : DP_DROP;
    end
  endtask

  task automatic deframe_predict(logic act, logic [30:0] len, logic [7:0] b);
    deframe_item_t e;
    longint lim;
    if (act == tpd_pkg::ACT_START) begin
      dphase = DP_TYPE; fld_cnt = 0; remaining = len; opts = 0; hdr_type = 0;
      seq_sh = 0; ts_sh = 0; cnt_sh = 0; sum_acc = 0; fill_idx = 0; cur_vp = 0;
      vp_left = 0; ent_w = 0;
      return;
    end
    case (dphase)
      DP_TYPE: begin
        hdr_type = b; remaining--;
        if (b != exp_type_r) push_header(tpd_pkg::ST_TYPE);
        else dphase = DP_VERSION;
      end
      DP_VERSION: begin
        remaining--;
        if (b != exp_ver_r) push_header(tpd_pkg::ST_VERSION);
        else dphase = DP_SUBVER;
      end
      DP_SUBVER: begin remaining--; dphase = DP_OPTIONS; end
      DP_OPTIONS: begin opts = b; remaining--; fld_cnt = 0; dphase = DP_SEQ; end
      DP_SEQ: begin
        seq_sh = {seq_sh[55:0], b}; remaining--;
        if (++fld_cnt == 8) begin
          fld_cnt = 0;
          dphase = ((opts & ts_mask_r) != 0) ? DP_TS : DP_COUNT;
        end
      end
      DP_TS: begin
        ts_sh = {ts_sh[55:0], b}; remaining--;
        if (++fld_cnt == 8) begin fld_cnt = 0; dphase = DP_COUNT; end
      end
      DP_COUNT: begin
        cnt_sh = {cnt_sh[23:0], b}; remaining--;
        if (++fld_cnt == 4) begin
          fld_cnt = 0;
          lim = (max_sub_r < MaxSub) ? max_sub_r : MaxSub;
          if (remaining < 0 || longint'(cnt_sh) > lim) begin
            push_header(tpd_pkg::ST_MAP);
          end else begin
            ent_w = ((opts & wide_mask_r) != 0) ? 4 : 2;
            remaining -= longint'(cnt_sh) * ent_w;
            if (remaining < 0) begin
              push_header(tpd_pkg::ST_MAP);
            end else begin
              fill_idx = 0; sum_acc = 0; vp_left = 0;
              if (cnt_sh == 0) close_map();
              else dphase = DP_SIZES;
            end
          end
        end
      end
      DP_SIZES: begin
        vp_left = {vp_left[23:0], b};
        if (++fld_cnt == ent_w) begin
          fld_cnt = 0;
          if (fill_idx < MaxSub) size_mem[fill_idx] = vp_left;
          sum_acc += vp_left;
          fill_idx++;
          vp_left = 0;
          if (fill_idx >= cnt_sh) close_map();
        end
      end
      DP_BODY: begin
        e = '{default: '0};
        e.kind = tpd_pkg::KIND_BODY;
        e.vp_idx = cur_vp[5:0];
        e.body = b;
        remaining--;
        vp_left--;
        if (vp_left == 0) begin
          e.eos = 1'b1;
          if (!find_nonempty(cur_vp + 1)) begin
            e.eop = 1'b1;
            dphase = DP_DROP;
          end
        end
        pending_q.push_back(e);
      end
      default: ;
    endcase
  endtask

  task automatic send_item(logic act, logic [30:0] len, logic [7:0] b);
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {1'b0, b, len};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    deframe_predict(act, len, b);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (Drain) @(posedge clk_i);
  endtask

  task automatic write_reg(tpd_pkg::cfg_idx_e idx, logic [7:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      tpd_pkg::CFG_TYPE:      exp_type_r  = val;
      tpd_pkg::CFG_VERSION:   exp_ver_r   = val;
      tpd_pkg::CFG_TS_MASK:   ts_mask_r   = val;
      tpd_pkg::CFG_WIDE_MASK: wide_mask_r = val;
      default:                max_sub_r   = val[6:0];
    endcase
  endtask

  task automatic set_regs(logic [7:0] t, logic [7:0] v, logic [7:0] tm, logic [7:0] wm,
                          logic [6:0] ms);
    drain_results();
    write_reg(tpd_pkg::CFG_TYPE, t);
    write_reg(tpd_pkg::CFG_VERSION, v);
    write_reg(tpd_pkg::CFG_TS_MASK, tm);
    write_reg(tpd_pkg::CFG_WIDE_MASK, wm);
    write_reg(tpd_pkg::CFG_MAX_SUB, {1'b0, ms});
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic push_field(logic [63:0] v, int nbytes);
    for (int i = nbytes - 1; i >= 0; i--) pkt_q.push_back(v[i*8 +: 8]);
  endtask

  // builds one packet against the current registers and sends it
  task automatic send_packet(pkt_flavor_e flavor, int n_vp, int max_len, logic [7:0] o);
    logic [31:0] sizes [$];
    logic [31:0] cnt;
    int unsigned body_len, total, w, lim;
    bit tsp;
    pkt_q.delete();
    lim  = (max_sub_r < MaxSub) ? max_sub_r : MaxSub;
    if (n_vp > lim) n_vp = lim;
    tsp  = (o & ts_mask_r) != 0;
    w    = ((o & wide_mask_r) != 0) ? 4 : 2;
    body_len = 0;
    for (int i = 0; i < n_vp; i++) begin
      sizes.push_back($urandom_range(3) == 0 ? 0 : $urandom_range(max_len));
      body_len += sizes[i];
    end
    cnt = n_vp;
    if (flavor == PK_OVER_COUNT)
      cnt = ($urandom_range(1)) ? lim + 32'd1 : $urandom;
    pkt_q.push_back(flavor == PK_BAD_TYPE ? exp_type_r ^ 8'($urandom_range(1, 255))
                                          : exp_type_r);
    pkt_q.push_back(flavor == PK_BAD_VERSION ? exp_ver_r ^ 8'($urandom_range(1, 255))
                                             : exp_ver_r);
    pkt_q.push_back(8'($urandom));
    pkt_q.push_back(o);
    push_field({$urandom, $urandom}, 8);
    if (tsp) push_field({$urandom, $urandom}, 8);
    push_field(64'(cnt), 4);
    foreach (sizes[i]) push_field(64'(sizes[i]), w);
    for (int i = 0; i < body_len; i++) pkt_q.push_back(8'($urandom));
    total = pkt_q.size();
    if (flavor == PK_BAD_LENGTH) begin
      if ($urandom_range(1) && total > 1) total -= $urandom_range(1, total);
      else total += $urandom_range(1, 40);
    end
    if (flavor == PK_CUT) pkt_q = pkt_q[0 : $urandom_range(pkt_q.size() - 1)];
    if (flavor == PK_TRAILING) repeat ($urandom_range(1, 4)) pkt_q.push_back(8'($urandom));
    send_item(tpd_pkg::ACT_START, 31'(total), 8'($urandom));
    foreach (pkt_q[i]) send_item(tpd_pkg::ACT_BYTE, 31'($urandom), pkt_q[i]);
  endtask

  task automatic test_directed();
    // bytes with no packet open
    send_item(tpd_pkg::ACT_BYTE, 31'h7fffffff, 8'hff);
    send_item(tpd_pkg::ACT_BYTE, 31'h0, 8'h00);
    set_regs(8'h00, 8'h04, 8'h01, 8'h02, 7'd64);
    send_packet(PK_GOOD, 0, 0, 8'h00);       // empty body
    send_packet(PK_GOOD, 4, 3, 8'h03);       // timestamp and wide sizes
    send_packet(PK_BAD_TYPE, 2, 2, 8'h00);
    send_packet(PK_BAD_VERSION, 2, 2, 8'h00);
    send_packet(PK_OVER_COUNT, 2, 2, 8'h00);
    send_packet(PK_BAD_LENGTH, 3, 2, 8'h02);
    send_packet(PK_CUT, 3, 4, 8'h01);
    send_packet(PK_TRAILING, 2, 3, 8'h00);
    send_packet(PK_GOOD, 64, 0, 8'h00);      // full table, all entries empty
  endtask

  task automatic test_extremes();
    set_regs(8'hff, 8'hff, 8'hff, 8'hff, 7'd0);
    send_packet(PK_GOOD, 0, 0, 8'hff);
    send_packet(PK_OVER_COUNT, 0, 0, 8'h80);
    set_regs(8'h00, 8'h00, 8'h00, 8'h00, 7'd127);
    send_packet(PK_GOOD, 64, 1, 8'($urandom));
    send_packet(PK_OVER_COUNT, 3, 1, 8'($urandom));
  endtask

  task automatic test_random(int n_pkt);
    pkt_flavor_e fl;
    int r;
    set_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
             7'($urandom_range(1, 70)));
    for (int p = 0; p < n_pkt; p++) begin
      r = $urandom_range(99);
      if (r < 8) begin
        // a start with any length, then noise
        send_item(tpd_pkg::ACT_START, 31'($urandom), 8'($urandom));
        repeat ($urandom_range(1, 6))
          send_item(tpd_pkg::ACT_BYTE, 31'($urandom), 8'($urandom));
      end else begin
        fl = (r < 65) ? PK_GOOD : pkt_flavor_e'($urandom_range(PK_BAD_TYPE, PK_TRAILING));
        send_packet(fl, $urandom_range(20) == 0 ? 64 : $urandom_range(6),
                    $urandom_range(20) == 0 ? 0 : $urandom_range(6), 8'($urandom));
      end
    end
  endtask

  // result checking
  task automatic chk(string name, logic [63:0] e, logic [63:0] g);
    if (e !== g) begin
      $display("%0t mismatch %s: expected %h actual %h", $time, name, e, g);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    deframe_item_t e;
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_q.size() == 0) begin
        $display("%0t unexpected item: expected none actual %h", $time, m_axis_tdata);
        errors++;
      end else begin
        e = pending_q.pop_front();
        chk("result_kind", e.kind, m_axis_tuser);
        chk("status", e.status, m_axis_tdata[1:0]);
        chk("packet_type", e.ptype, m_axis_tdata[9:2]);
        chk("sequence_number", e.seq, m_axis_tdata[73:10]);
        chk("time_stamp", e.ts, m_axis_tdata[121:74]);
        chk("subpacket_count", e.count, m_axis_tdata[128:122]);
        chk("subpacket_index", e.vp_idx, m_axis_tdata[134:129]);
        chk("body_byte", e.body, m_axis_tdata[142:135]);
        chk("end_of_subpacket", e.eos, m_axis_tdata[143]);
        chk("end_of_packet", e.eop, m_axis_tlast);
      end
    end
  end

  always @(posedge clk_i) m_axis_tready <= ($urandom_range(99) >= snk_stall);

  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o) || (!s_axis_tvalid && pending_q.size() == 0))
      quiet_cycles = 0;
    else if (++quiet_cycles >= Watchdog) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    exp_type_r = 8'h00; exp_ver_r = 8'h04; ts_mask_r = 8'h00; wide_mask_r = 8'h00;
    max_sub_r = 7'd64;
    dphase = DP_IDLE;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_extremes();
    test_random(2);
    src_idle = 62;
    test_random(2);
    src_idle = 0; snk_stall = 62;
    test_random(2);
    src_idle = 26; snk_stall = 26;
    test_random(2);
    drain_results();
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
